// ===== src/usbmsd_pkg.sv =====
// Package for the mass storage descriptor scanner: item and result types,
// descriptor codes and reset constants. No dependencies.
package usbmsd_pkg;

  localparam logic [7:0] KIND_CONFIGURATION = 8'd2;
  localparam logic [7:0] KIND_INTERFACE     = 8'd4;
  localparam logic [7:0] KIND_ENDPOINT      = 8'd5;
  localparam logic [7:0] MSC_CLASS          = 8'h08;
  localparam logic [7:0] SCSI_SUBCLASS      = 8'h06;
  localparam logic [7:0] BOT_PROTOCOL       = 8'h50;
  localparam logic [7:0] DIR_IN_BIT         = 8'h80;
  localparam logic [7:0] NO_INTERFACE       = 8'hFF;
  localparam logic [9:0] SIZE_AT_RESET      = 10'd4;
  localparam logic [9:0] CAP_AT_RESET       = 10'd64;
  localparam logic [15:0] LIMIT_AT_RESET    = 16'd256;

  // configuration register indexes
  localparam logic CFG_PACKET_SIZE_CAP  = 1'b0;
  localparam logic CFG_SET_LENGTH_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       clear_search;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] config_value;
    logic [7:0] interface_number;
    logic [3:0] in_endpoint_number;
    logic [9:0] in_packet_size;
    logic [3:0] out_endpoint_number;
    logic [9:0] out_packet_size;
    logic       too_long;
    logic       malformed;
  } result_t;

endpackage

// ===== src/usb_mass_storage_descriptor_scan_core.sv =====
// Top level of the mass storage descriptor scanner: input register, config
// registers and result register around usbmsd_scan. Depends on usbmsd_pkg.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   data_byte, first_byte, last_byte, clear_search
//   out      out_valid / out_ready found .. malformed (one request per last_byte)
//   cfg      cfg_we                cfg_index, cfg_data (no wait, no read-back)
//
// One byte per cycle sustained, unless a last byte waits on a stalled result.
// A byte sits in the input register, then the scan update runs and a last
// byte loads the result register. A stalled result holds only bytes that carry
// last_byte; others flow. Synchronous reset clears all but byte and result data.
module usb_mass_storage_descriptor_scan_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic        clear_search,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [7:0]  config_value,
  output logic [7:0]  interface_number,
  output logic [3:0]  in_endpoint_number,
  output logic [9:0]  in_packet_size,
  output logic [3:0]  out_endpoint_number,
  output logic [9:0]  out_packet_size,
  output logic        too_long,
  output logic        malformed,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [9:0]  packet_size_cap;
  logic [15:0] set_length_limit;

  logic                 stage_valid;
  usbmsd_pkg::in_item_t stage_item;
  logic                 stage_go;
  usbmsd_pkg::result_t  scan_res;
  usbmsd_pkg::result_t  out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_size_cap  <= usbmsd_pkg::CAP_AT_RESET;
      set_length_limit <= usbmsd_pkg::LIMIT_AT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        usbmsd_pkg::CFG_PACKET_SIZE_CAP:  packet_size_cap  <= cfg_data[9:0];
        usbmsd_pkg::CFG_SET_LENGTH_LIMIT: set_length_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // a byte without last_byte never needs the result register
  assign stage_go = stage_valid && (!stage_item.last_byte || !out_valid || out_ready);
  assign in_ready = !stage_valid || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item.data_byte    <= data_byte;
      stage_item.first_byte   <= first_byte;
      stage_item.last_byte    <= last_byte;
      stage_item.clear_search <= clear_search;
    end
  end

  usbmsd_scan u_scan (
    .clk              (clk),
    .rst              (rst),
    .step             (stage_go),
    .item             (stage_item),
    .packet_size_cap  (packet_size_cap),
    .set_length_limit (set_length_limit),
    .res              (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go && stage_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && stage_item.last_byte) begin
      out_res <= scan_res;
    end
  end

  assign found               = out_res.found;
  assign config_value        = out_res.config_value;
  assign interface_number    = out_res.interface_number;
  assign in_endpoint_number  = out_res.in_endpoint_number;
  assign in_packet_size      = out_res.in_packet_size;
  assign out_endpoint_number = out_res.out_endpoint_number;
  assign out_packet_size     = out_res.out_packet_size;
  assign too_long            = out_res.too_long;
  assign malformed           = out_res.malformed;

endmodule

// ===== src/usbmsd_scan.sv =====
// Descriptor walk state and the per-byte update; one byte per step.
// Depends on usbmsd_pkg.
module usbmsd_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  usbmsd_pkg::in_item_t item,
  input  logic [9:0]          packet_size_cap,
  input  logic [15:0]         set_length_limit,
  output usbmsd_pkg::result_t res
);

  logic [15:0] stream_position, stream_position_next;
  logic [15:0] set_total_length, set_total_length_next;
  logic [7:0]  offset_in_descriptor, offset_in_descriptor_next;
  logic [7:0]  desc_length, desc_length_next;
  logic [7:0]  descriptor_kind, descriptor_kind_next;
  logic [1:0]  class_match_bits, class_match_bits_next;
  logic [7:0]  endpoint_address_byte, endpoint_address_byte_next;
  logic [7:0]  packet_size_low_byte, packet_size_low_byte_next;
  logic [7:0]  current_config_value, current_config_value_next;
  logic [7:0]  current_interface, current_interface_next;
  logic        search_found, search_found_next;
  logic [7:0]  found_config, found_config_next;
  logic [7:0]  found_interface, found_interface_next;
  logic [3:0]  in_endpoint, in_endpoint_next;
  logic [9:0]  in_size, in_size_next;
  logic [3:0]  out_endpoint, out_endpoint_next;
  logic [9:0]  out_size, out_size_next;
  logic        length_error, length_error_next;
  logic        zero_length_error, zero_length_error_next;

  always_comb begin
    logic [15:0] pos;
    logic [7:0]  off;
    logic [7:0]  b;
    logic [15:0] size;
    logic [9:0]  size_clamped;

    b    = item.data_byte;
    size = '0;
    size_clamped = '0;

    stream_position_next       = stream_position;
    set_total_length_next      = set_total_length;
    offset_in_descriptor_next  = offset_in_descriptor;
    desc_length_next           = desc_length;
    descriptor_kind_next       = descriptor_kind;
    class_match_bits_next      = class_match_bits;
    endpoint_address_byte_next = endpoint_address_byte;
    packet_size_low_byte_next  = packet_size_low_byte;
    current_config_value_next  = current_config_value;
    current_interface_next     = current_interface;
    search_found_next          = search_found;
    found_config_next          = found_config;
    found_interface_next       = found_interface;
    in_endpoint_next           = in_endpoint;
    in_size_next               = in_size;
    out_endpoint_next          = out_endpoint;
    out_size_next              = out_size;
    length_error_next          = length_error;
    zero_length_error_next     = zero_length_error;

    // set start clears counters first; the byte is then parsed from there
    if (item.first_byte) begin
      stream_position_next       = '0;
      set_total_length_next      = '0;
      offset_in_descriptor_next  = '0;
      desc_length_next           = '0;
      descriptor_kind_next       = '0;
      class_match_bits_next      = '0;
      endpoint_address_byte_next = '0;
      packet_size_low_byte_next  = '0;
      length_error_next          = 1'b0;
      zero_length_error_next     = 1'b0;
      if (item.clear_search) begin
        current_config_value_next = '0;
        current_interface_next    = '0;
        search_found_next         = 1'b0;
        found_config_next         = '0;
        found_interface_next      = usbmsd_pkg::NO_INTERFACE;
        in_endpoint_next          = '0;
        in_size_next              = usbmsd_pkg::SIZE_AT_RESET;
        out_endpoint_next         = '0;
        out_size_next             = usbmsd_pkg::SIZE_AT_RESET;
      end
    end

    pos = stream_position_next;
    off = offset_in_descriptor_next;

    if (pos != 16'hFFFF) begin
      stream_position_next = pos + 16'd1;
    end

    if (!(length_error_next || zero_length_error_next) &&
        !(pos >= 16'd4 && pos >= set_total_length_next)) begin
      if (pos == 16'd2) begin
        set_total_length_next = {8'h00, b};
      end else if (pos == 16'd3) begin
        set_total_length_next = set_total_length_next | {b, 8'h00};
      end

      if (off == 8'd0) begin
        desc_length_next      = b;
        descriptor_kind_next  = '0;
        class_match_bits_next = '0;
        if (b == 8'd0) begin
          zero_length_error_next = 1'b1;
        end
      end else if (off == 8'd1) begin
        descriptor_kind_next = b;
      end else begin
        case (descriptor_kind_next)
          usbmsd_pkg::KIND_CONFIGURATION: begin
            if (off == 8'd5) current_config_value_next = b;
          end
          usbmsd_pkg::KIND_INTERFACE: begin
            if (off == 8'd2) begin
              current_interface_next = b;
            end else if (off == 8'd5) begin
              class_match_bits_next = (b == usbmsd_pkg::MSC_CLASS) ? 2'd1 : 2'd0;
            end else if (off == 8'd6) begin
              class_match_bits_next =
                (class_match_bits_next[0] && b == usbmsd_pkg::SCSI_SUBCLASS) ? 2'd3 : 2'd0;
            end else if (off == 8'd7) begin
              if (class_match_bits_next == 2'd3 && b == usbmsd_pkg::BOT_PROTOCOL) begin
                search_found_next    = 1'b1;
                found_config_next    = current_config_value_next;
                found_interface_next = current_interface_next;
              end
            end
          end
          usbmsd_pkg::KIND_ENDPOINT: begin
            if (off == 8'd2) begin
              endpoint_address_byte_next = b;
            end else if (off == 8'd4) begin
              packet_size_low_byte_next = b;
            end else if (off == 8'd5) begin
              size = {b, packet_size_low_byte_next};
              size_clamped = (size > {6'd0, packet_size_cap}) ? packet_size_cap : size[9:0];
              if (search_found_next && current_interface_next == found_interface_next) begin
                if ((endpoint_address_byte_next & usbmsd_pkg::DIR_IN_BIT) != 8'd0) begin
                  in_endpoint_next = endpoint_address_byte_next[3:0];
                  in_size_next     = size_clamped;
                end else begin
                  out_endpoint_next = endpoint_address_byte_next[3:0];
                  out_size_next     = size_clamped;
                end
              end
            end
          end
          default: ;
        endcase
      end

      // a zero length byte stops the set before the offset and length checks
      if (!(off == 8'd0 && b == 8'd0)) begin
        if (({1'b0, off} + 9'd1) >= {1'b0, desc_length_next}) begin
          offset_in_descriptor_next = '0;
        end else begin
          offset_in_descriptor_next = off + 8'd1;
        end
        if (pos == 16'd3 && set_total_length_next > set_length_limit) begin
          length_error_next = 1'b1;
        end
      end
    end

    res.found               = search_found_next;
    res.config_value        = found_config_next;
    res.interface_number    = found_interface_next;
    res.in_endpoint_number  = in_endpoint_next;
    res.in_packet_size      = in_size_next;
    res.out_endpoint_number = out_endpoint_next;
    res.out_packet_size     = out_size_next;
    res.too_long            = length_error_next;
    res.malformed           = zero_length_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_position       <= '0;
      set_total_length      <= '0;
      offset_in_descriptor  <= '0;
      desc_length           <= '0;
      descriptor_kind       <= '0;
      class_match_bits      <= '0;
      endpoint_address_byte <= '0;
      packet_size_low_byte  <= '0;
      current_config_value  <= '0;
      current_interface     <= '0;
      search_found          <= 1'b0;
      found_config          <= '0;
      found_interface       <= usbmsd_pkg::NO_INTERFACE;
      in_endpoint           <= '0;
      in_size               <= usbmsd_pkg::SIZE_AT_RESET;
      out_endpoint          <= '0;
      out_size              <= usbmsd_pkg::SIZE_AT_RESET;
      length_error          <= 1'b0;
      zero_length_error     <= 1'b0;
    end else if (step) begin
      stream_position       <= stream_position_next;
      set_total_length      <= set_total_length_next;
      offset_in_descriptor  <= offset_in_descriptor_next;
      desc_length           <= desc_length_next;
      descriptor_kind       <= descriptor_kind_next;
      class_match_bits      <= class_match_bits_next;
      endpoint_address_byte <= endpoint_address_byte_next;
      packet_size_low_byte  <= packet_size_low_byte_next;
      current_config_value  <= current_config_value_next;
      current_interface     <= current_interface_next;
      search_found          <= search_found_next;
      found_config          <= found_config_next;
      found_interface       <= found_interface_next;
      in_endpoint           <= in_endpoint_next;
      in_size               <= in_size_next;
      out_endpoint          <= out_endpoint_next;
      out_size              <= out_size_next;
      length_error          <= length_error_next;
      zero_length_error     <= zero_length_error_next;
    end
  end

endmodule
